@@ rtl/hjr_pkg.sv @@
// hjr_pkg: types and constants for the heading jibe and run detector.
// Used by hjr_divider and heading_jibe_run_detector; depends on nothing.
`default_nettype none
package hjr_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DEN_W      = 14;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_RATE     = 3'd0,
		REG_MEAN_TIME_S     = 3'd1,
		REG_NEW_RUN_DELAY_S = 3'd2,
		REG_SPEED_START_MIN = 3'd3,
		REG_SPEED_STOP_MAX  = 3'd4,
		REG_STRAIGHT_DEV    = 3'd5,
		REG_JIBE_DEV        = 3'd6
	} cfg_reg_t;

	localparam logic [5:0]  RST_SAMPLE_RATE     = 6'd10;
	localparam logic [7:0]  RST_MEAN_TIME_S     = 8'd15;
	localparam logic [7:0]  RST_NEW_RUN_DELAY_S = 8'd10;
	localparam logic [15:0] RST_SPEED_START_MIN = 16'd4000;
	localparam logic [15:0] RST_SPEED_STOP_MAX  = 16'd1000;
	localparam logic [14:0] RST_STRAIGHT_DEV    = 15'd1000;
	localparam logic [14:0] RST_JIBE_DEV        = 15'd5000;

	localparam logic signed [16:0] WRAP_LIMIT = 17'sd30000;
	localparam logic [31:0]        FULL_TURN  = 32'd36000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UNWRAP,
		S_NUM,
		S_START,
		S_DIV,
		S_FLAGS,
		S_DIFF,
		S_EVT,
		S_DONE
	} hjr_state_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_ITER,
		D_FIX
	} div_state_t;

endpackage
`default_nettype wire

@@ rtl/hjr_divider.sv @@
// hjr_divider: iterative signed-by-unsigned floor divider, one quotient bit per cycle.
// Depends on hjr_pkg (DEN_W, div_state_t).
`default_nettype none
module hjr_divider import hjr_pkg::*; #(
	parameter int NUM_W = 49
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0]        den,
	output logic                         done,
	output logic signed [NUM_W-1:0]      quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	div_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] mag_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic             done_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q, mag_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			D_IDLE: if (start) state_d = D_ITER;
			D_ITER: if (cnt_q == '0) state_d = D_FIX;
			D_FIX:  state_d = D_IDLE;
			default: state_d = D_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == D_FIX);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (start) begin
					neg_q <= num[NUM_W-1];
					mag_q <= num[NUM_W-1] ? (~num + 1'b1) : num;
					den_q <= den;
					rem_q <= '0;
					cnt_q <= CNT_W'(NUM_W - 1);
				end
			end
			D_ITER: begin
				rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
				mag_q <= {mag_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			D_FIX: begin
				// floor for negative: -(q + (r != 0)) = ~q + (r == 0)
				quo_q <= neg_q ? (~mag_q + NUM_W'(rem_q == '0)) : mag_q;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quo  = $signed(quo_q);

endmodule
`default_nettype wire

@@ rtl/heading_jibe_run_detector.sv @@
// heading_jibe_run_detector: heading unwrap, exponential mean, speed hysteresis, jibe/run events.
// Depends on hjr_pkg and hjr_divider.
//
//   channel | signals                                   | handshake
//   input   | heading_in, speed_in, sample_index        | in_valid / in_stall
//   output  | unwrapped_heading .. last_run_index       | out_valid / out_stall
//   config  | cfg_we, cfg_addr, cfg_wdata               | write on cfg_we
//
// The serial mean divider works one quotient bit a cycle over 33 + MEAN_FRAC_BITS bits.
// in_stall is high while an item is in work; a waiting result holds the last step.
// Reset is asynchronous; no clearing pass.
`default_nettype none
module heading_jibe_run_detector import hjr_pkg::*; #(
	parameter int MEAN_FRAC_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [15:0]           heading_in,
	input  wire logic [15:0]           speed_in,
	input  wire logic [30:0]           sample_index,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [31:0]         unwrapped_heading,
	output logic signed [31:0]         mean_heading_out,
	output logic                       jibe_now,
	output logic                       new_run_now,
	output logic [15:0]                run_total,
	output logic [15:0]                jibe_total,
	output logic signed [31:0]         last_jibe_index,
	output logic signed [31:0]         last_run_index
);

	localparam int F  = MEAN_FRAC_BITS;
	localparam int MW = 32 + F;
	localparam int NW = MW + 1;

	// configuration
	logic [5:0]  sample_rate_q;
	logic [7:0]  mean_time_s_q;
	logic [7:0]  new_run_delay_s_q;
	logic [15:0] speed_start_min_q;
	logic [15:0] speed_stop_max_q;
	logic [14:0] straight_dev_q;
	logic [14:0] jibe_dev_q;

	// model state
	logic [15:0]          prev_head_q;
	logic [31:0]          offset_q;
	logic signed [MW-1:0] mean_q;
	logic                 fast_q;
	logic                 stopped_q;
	logic                 armed_q;
	logic [31:0]          delay_q;
	logic [15:0]          run_cnt_q;
	logic [15:0]          jibe_cnt_q;
	logic [31:0]          jibe_idx_q;
	logic [31:0]          run_idx_q;

	// per-item work registers
	hjr_state_t           state_q, state_d;
	logic [15:0]          hin_q;
	logic [15:0]          spd_q;
	logic [30:0]          idx_q;
	logic [31:0]          head_u_q;
	logic [DEN_W-1:0]     n_q;
	logic signed [NW-1:0] num_q;
	logic signed [NW-1:0] diff_q;
	logic                 jibe_q;

	// output registers
	logic                 out_valid_q;
	logic [31:0]          o_head_q;
	logic [31:0]          o_mean_q;
	logic                 o_jibe_q;
	logic                 o_run_q;
	logic [15:0]          o_run_cnt_q;
	logic [15:0]          o_jibe_cnt_q;
	logic [31:0]          o_jibe_idx_q;
	logic [31:0]          o_run_idx_q;

	logic                 in_acc;
	logic                 out_free;
	logic                 div_start;
	logic                 div_done;
	logic signed [NW-1:0] div_quo;

	logic signed [16:0]   hd;
	logic [31:0]          off_n;
	logic [DEN_W-1:0]     n_raw;
	logic [DEN_W-1:0]     tgt;
	logic [MW-1:0]        head_fix;
	logic                 spd_gt;
	logic                 spd_lt;
	logic                 fast1, stop1, restart;
	logic [NW-1:0]        dev;
	logic [NW-1:0]        str_lim, jib_lim;
	logic                 armed_n;
	logic                 jibe;
	logic [31:0]          dc1;
	logic                 run_hit;
	logic [MW-1:0]        mean_upd;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = S_UNWRAP;
			end
			S_UNWRAP: state_d = S_NUM;
			S_NUM:    state_d = S_START;
			S_START: begin
				div_start = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV:   if (div_done) state_d = S_FLAGS;
			S_FLAGS: state_d = S_DIFF;
			S_DIFF:  state_d = S_EVT;
			S_EVT:   state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	hjr_divider #(.NUM_W(NW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (n_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign hd       = $signed({1'b0, hin_q}) - $signed({1'b0, prev_head_q});
	assign off_n    = (hd > WRAP_LIMIT) ? (offset_q - FULL_TURN) :
	                  (hd < -WRAP_LIMIT) ? (offset_q + FULL_TURN) : offset_q;
	assign n_raw    = DEN_W'({6'd0, mean_time_s_q} * {8'd0, sample_rate_q});
	assign tgt      = DEN_W'({6'd0, new_run_delay_s_q} * {8'd0, sample_rate_q});
	assign head_fix = {head_u_q, {F{1'b0}}};
	assign mean_upd = MW'(mean_q + div_quo[MW-1:0]);

	assign spd_gt  = spd_q > speed_start_min_q;
	assign spd_lt  = spd_q < speed_stop_max_q;
	assign fast1   = fast_q | spd_gt;
	assign stop1   = stopped_q | (spd_lt & fast1);
	assign restart = stop1 & spd_gt;

	assign dev     = diff_q[NW-1] ? (~diff_q + 1'b1) : diff_q;
	assign str_lim = {{(NW - 15 - F){1'b0}}, straight_dev_q, {F{1'b0}}};
	assign jib_lim = {{(NW - 15 - F){1'b0}}, jibe_dev_q, {F{1'b0}}};
	assign armed_n = armed_q | ((dev < str_lim) & spd_gt);
	assign jibe    = (dev > jib_lim) & armed_n;

	assign dc1     = delay_q + 32'd1;
	assign run_hit = dc1 == {{(32 - DEN_W){1'b0}}, tgt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q     <= RST_SAMPLE_RATE;
			mean_time_s_q     <= RST_MEAN_TIME_S;
			new_run_delay_s_q <= RST_NEW_RUN_DELAY_S;
			speed_start_min_q <= RST_SPEED_START_MIN;
			speed_stop_max_q  <= RST_SPEED_STOP_MAX;
			straight_dev_q    <= RST_STRAIGHT_DEV;
			jibe_dev_q        <= RST_JIBE_DEV;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SAMPLE_RATE:     sample_rate_q     <= cfg_wdata[5:0];
				REG_MEAN_TIME_S:     mean_time_s_q     <= cfg_wdata[7:0];
				REG_NEW_RUN_DELAY_S: new_run_delay_s_q <= cfg_wdata[7:0];
				REG_SPEED_START_MIN: speed_start_min_q <= cfg_wdata;
				REG_SPEED_STOP_MAX:  speed_stop_max_q  <= cfg_wdata;
				REG_STRAIGHT_DEV:    straight_dev_q    <= cfg_wdata[14:0];
				REG_JIBE_DEV:        jibe_dev_q        <= cfg_wdata[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_head_q <= '0;
			offset_q    <= '0;
			mean_q      <= '0;
			fast_q      <= 1'b0;
			stopped_q   <= 1'b0;
			armed_q     <= 1'b0;
			delay_q     <= '0;
			run_cnt_q   <= '0;
			jibe_cnt_q  <= '0;
			jibe_idx_q  <= '1;
			run_idx_q   <= '1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_UNWRAP: begin
					offset_q    <= off_n;
					prev_head_q <= hin_q;
				end
				S_DIV: if (div_done) mean_q <= mean_upd;
				S_FLAGS: begin
					fast_q    <= restart ? 1'b0 : fast1;
					stopped_q <= restart ? 1'b0 : stop1;
					if (restart) delay_q <= {{(32 - DEN_W){1'b0}}, tgt} - {26'd0, sample_rate_q};
				end
				S_EVT: begin
					armed_q <= jibe ? 1'b0 : armed_n;
					if (jibe) begin
						delay_q    <= '0;
						jibe_cnt_q <= jibe_cnt_q + 16'd1;
						jibe_idx_q <= {1'b0, idx_q};
					end
				end
				S_DONE: begin
					if (out_free) begin
						delay_q <= dc1;
						if (run_hit) begin
							run_cnt_q <= run_cnt_q + 16'd1;
							run_idx_q <= {1'b0, idx_q};
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hin_q <= heading_in;
			spd_q <= speed_in;
			idx_q <= sample_index;
		end
		case (state_q)
			S_UNWRAP: begin
				head_u_q <= hin_q + off_n;
				n_q      <= (n_raw == '0) ? DEN_W'(1) : n_raw;
			end
			S_NUM:  num_q  <= $signed({head_fix[MW-1], head_fix}) - $signed({mean_q[MW-1], mean_q});
			S_DIFF: diff_q <= $signed({head_fix[MW-1], head_fix}) - $signed({mean_q[MW-1], mean_q});
			S_EVT:  jibe_q <= jibe;
			S_DONE: begin
				if (out_free) begin
					o_head_q     <= head_u_q;
					o_mean_q     <= mean_q[MW-1:F];
					o_jibe_q     <= jibe_q;
					o_run_q      <= run_hit;
					o_run_cnt_q  <= run_hit ? (run_cnt_q + 16'd1) : run_cnt_q;
					o_jibe_cnt_q <= jibe_cnt_q;
					o_jibe_idx_q <= jibe_idx_q;
					o_run_idx_q  <= run_hit ? {1'b0, idx_q} : run_idx_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid         = out_valid_q;
	assign unwrapped_heading = $signed(o_head_q);
	assign mean_heading_out  = $signed(o_mean_q);
	assign jibe_now          = o_jibe_q;
	assign new_run_now       = o_run_q;
	assign run_total         = o_run_cnt_q;
	assign jibe_total        = o_jibe_cnt_q;
	assign last_jibe_index   = $signed(o_jibe_idx_q);
	assign last_run_index    = $signed(o_run_idx_q);

endmodule
`default_nettype wire

@@ tb/hjr_checker.sv @@
// hjr_checker: predicts every item of heading_jibe_run_detector and checks the results in order.
// Watches the config port and both channels; depends on hjr_pkg.
module hjr_checker import hjr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [15:0]           heading_in,
	input  logic [15:0]           speed_in,
	input  logic [30:0]           sample_index,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [31:0]           unwrapped_heading,
	input  logic [31:0]           mean_heading_out,
	input  logic                  jibe_now,
	input  logic                  new_run_now,
	input  logic [15:0]           run_total,
	input  logic [15:0]           jibe_total,
	input  logic [31:0]           last_jibe_index,
	input  logic [31:0]           last_run_index,
	output int                    errors,
	output int                    pending
);

	localparam int TURN_LIMIT = 30000;
	localparam int TURN       = 36000;

	typedef struct packed {
		logic [31:0] unwrapped;
		logic [31:0] mean;
		logic        jibe;
		logic        run;
		logic [15:0] runs;
		logic [15:0] jibes;
		logic [31:0] jibe_at;
		logic [31:0] run_at;
	} sample_result_t;

	logic [5:0]  cfg_rate;
	logic [7:0]  cfg_mean_s;
	logic [7:0]  cfg_delay_s;
	logic [15:0] cfg_start;
	logic [15:0] cfg_stop;
	logic [14:0] cfg_sdev;
	logic [14:0] cfg_jdev;

	logic [15:0] prev_hdg;
	logic [31:0] hdg_offset;
	longint      mean_acc;
	bit          fast_seen, stopped_seen, armed;
	logic [31:0] delay_cnt;
	logic [15:0] run_cnt, jibe_cnt;
	logic [31:0] jibe_idx, run_idx;

	sample_result_t awaited[$];
	sample_result_t want;

	function automatic sample_result_t predict_sample(input logic [15:0] hin,
			input logic [15:0] spd, input logic [30:0] idx);
		int             d;
		logic [31:0]    head_u, n, target;
		longint         head_fix, num, q, dev;
		sample_result_t r;
		d = int'({16'd0, hin}) - int'({16'd0, prev_hdg});
		if (d > TURN_LIMIT)
			hdg_offset = hdg_offset - TURN;
		if (d < -TURN_LIMIT)
			hdg_offset = hdg_offset + TURN;
		prev_hdg = hin;
		head_u = {16'd0, hin} + hdg_offset;
		head_fix = longint'($signed(head_u)) * (longint'(1) << FRAC_BITS);

		n = {24'd0, cfg_mean_s} * {26'd0, cfg_rate};
		if (n == 0)
			n = 1;
		num = head_fix - mean_acc;
		q = num / longint'(n);
		if (num < 0 && q * longint'(n) != num)
			q = q - 1;
		mean_acc = mean_acc + q;

		if (spd > cfg_start)
			fast_seen = 1;
		if (spd < cfg_stop && fast_seen)
			stopped_seen = 1;
		if (stopped_seen && spd > cfg_start) begin
			stopped_seen = 0;
			fast_seen = 0;
			delay_cnt = ({24'd0, cfg_delay_s} - 32'd1) * {26'd0, cfg_rate};
		end

		num = head_fix - mean_acc;
		dev = (num < 0) ? -num : num;
		if (dev < (longint'(cfg_sdev) << FRAC_BITS) && spd > cfg_start)
			armed = 1;
		r.jibe = 1'b0;
		r.run = 1'b0;
		if (dev > (longint'(cfg_jdev) << FRAC_BITS) && armed) begin
			armed = 0;
			delay_cnt = 0;
			jibe_cnt = jibe_cnt + 16'd1;
			jibe_idx = {1'b0, idx};
			r.jibe = 1'b1;
		end

		delay_cnt = delay_cnt + 32'd1;
		target = {24'd0, cfg_delay_s} * {26'd0, cfg_rate};
		if (delay_cnt == target) begin
			run_cnt = run_cnt + 16'd1;
			run_idx = {1'b0, idx};
			r.run = 1'b1;
		end

		r.unwrapped = head_u;
		r.mean = 32'(mean_acc >>> FRAC_BITS);
		r.runs = run_cnt;
		r.jibes = jibe_cnt;
		r.jibe_at = jibe_idx;
		r.run_at = run_idx;
		return r;
	endfunction

	task automatic compare_field(input string label, input logic [31:0] exp_v,
			input logic [31:0] got);
		if (exp_v !== got) begin
			errors++;
			$display("%0t: %s expected %h got %h", $time, label, exp_v, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_rate = RST_SAMPLE_RATE;
			cfg_mean_s = RST_MEAN_TIME_S;
			cfg_delay_s = RST_NEW_RUN_DELAY_S;
			cfg_start = RST_SPEED_START_MIN;
			cfg_stop = RST_SPEED_STOP_MAX;
			cfg_sdev = RST_STRAIGHT_DEV;
			cfg_jdev = RST_JIBE_DEV;
			prev_hdg = '0;
			hdg_offset = '0;
			mean_acc = 0;
			fast_seen = 0;
			stopped_seen = 0;
			armed = 0;
			delay_cnt = '0;
			run_cnt = '0;
			jibe_cnt = '0;
			jibe_idx = '1;
			run_idx = '1;
			awaited.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_SAMPLE_RATE:     cfg_rate = cfg_wdata[5:0];
					REG_MEAN_TIME_S:     cfg_mean_s = cfg_wdata[7:0];
					REG_NEW_RUN_DELAY_S: cfg_delay_s = cfg_wdata[7:0];
					REG_SPEED_START_MIN: cfg_start = cfg_wdata;
					REG_SPEED_STOP_MAX:  cfg_stop = cfg_wdata;
					REG_STRAIGHT_DEV:    cfg_sdev = cfg_wdata[14:0];
					REG_JIBE_DEV:        cfg_jdev = cfg_wdata[14:0];
					default: ;
				endcase
			end
			// result before new item: a result taken at this edge is never for it
			if (out_valid && !out_stall) begin
				if (awaited.size() == 0) begin
					errors++;
					$display("%0t: result expected none got heading %h",
						$time, unwrapped_heading);
				end else begin
					want = awaited.pop_front();
					compare_field("unwrapped_heading", want.unwrapped, unwrapped_heading);
					compare_field("mean_heading_out", want.mean, mean_heading_out);
					compare_field("jibe_now", 32'(want.jibe), 32'(jibe_now));
					compare_field("new_run_now", 32'(want.run), 32'(new_run_now));
					compare_field("run_total", 32'(want.runs), 32'(run_total));
					compare_field("jibe_total", 32'(want.jibes), 32'(jibe_total));
					compare_field("last_jibe_index", want.jibe_at, last_jibe_index);
					compare_field("last_run_index", want.run_at, last_run_index);
				end
			end
			if (in_valid && !in_stall)
				awaited.push_back(predict_sample(heading_in, speed_in, sample_index));
			pending = awaited.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// testbench: drives GPS samples and register settings into heading_jibe_run_detector.
// Depends on hjr_pkg, the block and hjr_checker, which predicts and compares.
module testbench;
	import hjr_pkg::*;

	localparam int FRAC = 16;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_reg_t              cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_stall;
	logic [15:0]           heading_in;
	logic [15:0]           speed_in;
	logic [30:0]           sample_index;
	logic                  out_valid;
	logic                  out_stall;
	logic signed [31:0]    unwrapped_heading;
	logic signed [31:0]    mean_heading_out;
	logic                  jibe_now;
	logic                  new_run_now;
	logic [15:0]           run_total;
	logic [15:0]           jibe_total;
	logic signed [31:0]    last_jibe_index;
	logic signed [31:0]    last_run_index;
	int                    errors;
	int                    pending;

	bit          calm;
	bit          hold_req;
	bit          hold_done;
	int          course;
	logic [30:0] next_idx;
	logic [15:0] cur_start;
	logic [15:0] cur_stop;

	heading_jibe_run_detector #(.MEAN_FRAC_BITS(FRAC)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.heading_in(heading_in), .speed_in(speed_in), .sample_index(sample_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.unwrapped_heading(unwrapped_heading), .mean_heading_out(mean_heading_out),
		.jibe_now(jibe_now), .new_run_now(new_run_now),
		.run_total(run_total), .jibe_total(jibe_total),
		.last_jibe_index(last_jibe_index), .last_run_index(last_run_index)
	);

	hjr_checker #(.FRAC_BITS(FRAC)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.heading_in(heading_in), .speed_in(speed_in), .sample_index(sample_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.unwrapped_heading(unwrapped_heading), .mean_heading_out(mean_heading_out),
		.jibe_now(jibe_now), .new_run_now(new_run_now),
		.run_total(run_total), .jibe_total(jibe_total),
		.last_jibe_index(last_jibe_index), .last_run_index(last_run_index),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random stall bursts, one long hold-off on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				hold_done = 1;
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic offer(input logic [15:0] h, input logic [15:0] s,
			input logic [30:0] idx, input bit last);
		heading_in <= h;
		speed_in <= s;
		sample_index <= idx;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (last) begin
			in_valid <= 1'b0;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= r;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] rate, input logic [15:0] mean_s,
			input logic [15:0] delay_s, input logic [15:0] start, input logic [15:0] stop,
			input logic [15:0] sdev, input logic [15:0] jdev);
		write_reg(REG_SAMPLE_RATE, rate);
		write_reg(REG_MEAN_TIME_S, mean_s);
		write_reg(REG_NEW_RUN_DELAY_S, delay_s);
		write_reg(REG_SPEED_START_MIN, start);
		write_reg(REG_SPEED_STOP_MAX, stop);
		write_reg(REG_STRAIGHT_DEV, sdev);
		write_reg(REG_JIBE_DEV, jdev);
		cfg_we <= 1'b0;
		cur_start = start;
		cur_stop = stop;
		@(posedge clk);
	endtask

	// a sailing leg: steady course with small noise, turns, stops, and some junk items
	task automatic sail_leg(input int count);
		int          k, roll, turn, hd, stop_left;
		logic [15:0] h, s;
		logic [30:0] idx;
		stop_left = 0;
		course = ($urandom_range(0, 2) == 0) ? $urandom_range(35800, 35999)
			: $urandom_range(0, 35999);
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				h = 16'($urandom);
				s = 16'($urandom);
				idx = 31'($urandom);
				next_idx = idx;
			end else begin
				if (roll < 16) begin
					turn = $urandom_range(6000, 17000);
					course = ($urandom_range(0, 1) == 1) ? course + turn : course + 36000 - turn;
					course = course % 36000;
				end else if (roll < 22 && stop_left == 0) begin
					stop_left = $urandom_range(1, 4);
				end
				hd = course + $urandom_range(0, 400) - 200;
				if (hd < 0)
					hd += 36000;
				if (hd >= 36000)
					hd -= 36000;
				h = 16'(hd);
				if (stop_left > 0) begin
					stop_left--;
					s = (cur_stop == 0) ? 16'd0 : 16'($urandom_range(0, cur_stop - 1));
				end else begin
					s = (cur_start == 16'hFFFF) ? 16'hFFFF
						: 16'($urandom_range(cur_start + 1, 65535));
				end
				idx = next_idx;
			end
			next_idx = idx + 31'd1;
			offer(h, s, idx, k == count - 1);
		end
	endtask

	initial begin
		int p;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_SAMPLE_RATE;
		cfg_wdata = '0;
		in_valid = 1'b0;
		heading_in = '0;
		speed_in = '0;
		sample_index = '0;
		calm = 0;
		hold_req = 0;
		hold_done = 0;
		cur_start = RST_SPEED_START_MIN;
		cur_stop = RST_SPEED_STOP_MAX;
		next_idx = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: arm, jibe, seam crossings both ways, wrap boundaries, restart
		offer(16'd0, 16'd5000, 31'd0, 0);
		offer(16'd0, 16'd4001, 31'd1, 0);
		offer(16'd9000, 16'd5000, 31'd2, 0);
		offer(16'd35999, 16'd4000, 31'd3, 0);
		offer(16'd0, 16'd4000, 31'd4, 0);
		offer(16'd35999, 16'd1000, 31'd5, 0);
		offer(16'd65535, 16'd999, 31'd6, 0);
		offer(16'd0, 16'd0, 31'd7, 0);
		offer(16'd30000, 16'd65535, 31'd8, 0);
		offer(16'd0, 16'd65535, 31'd9, 0);
		offer(16'd30001, 16'd5000, 31'd10, 0);
		offer(16'd0, 16'd5000, 31'd11, 0);
		offer(16'd18000, 16'd5000, 31'h7FFFFFFF, 0);
		offer(16'd0, 16'd5000, 31'h2AAAAAAA, 0);
		offer(16'd0, 16'd5000, 31'h55555555, 1);
		drain();

		next_idx = 31'($urandom_range(0, 1000000));
		for (p = 1; p <= 14; p++) begin
			case (p)
				1: program_regs(16'd1, 16'd2, 16'd3, 16'd4000, 16'd1000, 16'd1500, 16'd5000);
				2: program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
				3: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'hFFFF);
				4: program_regs(16'd50, 16'd1, 16'd1, 16'd100, 16'd50, 16'd18000, 16'd18000);
				5: program_regs(16'd2, 16'd1, 16'd2, 16'd3000, 16'd500, 16'd2000, 16'd4000);
				6: program_regs(16'd1, 16'd255, 16'd255, 16'd4000, 16'd1000, 16'd1000, 16'd5000);
				default: program_regs(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
					16'($urandom_range(1, 5)), 16'($urandom_range(2000, 6000)),
					16'($urandom_range(200, 1999)), 16'($urandom_range(500, 3000)),
					16'($urandom_range(3000, 9000)));
			endcase
			if (p == 5)
				hold_req = 1;
			if (p == 14)
				calm = 1;
			sail_leg(50);
			drain();
		end

		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ heading_jibe_run_detector.f @@
rtl/hjr_pkg.sv
rtl/hjr_divider.sv
rtl/heading_jibe_run_detector.sv
tb/hjr_checker.sv
tb/testbench.sv
